>>> rtl/bitmap_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bitmap_block_allocator: assertion failed");
`define BBA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bitmap_block_allocator: assertion failed");
`else
`define BBA_ASSERT(lbl, clk, rst, prop)
`define BBA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Sizes, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int MAX_BLOCKS = 4096;
   localparam int WORD_BITS  = 64;
   localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(WORD_COUNT);
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int BLOCK_W    = 12;
   localparam int COUNT_W    = 13;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_MARK  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_NOSPACE = 2'd2,
      ST_SAME    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MARK,
      S_RESP
   } state_type;

endpackage

>>> rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a used/free bitmap of blocks, one RAM word per 64
// blocks, with a count of used blocks. Allocate, free, mark used, clear all.
//
//   channel  ports                                     direction
//   req      req_valid/req_stall, command, target       in
//   rsp      rsp_valid/rsp_stall, status, granted, used out
//   csr      csr_wr_en, csr_wr_data (block_count)       in
//
// Allocate: one bitmap word scanned per cycle, up to 64, between the accept and
// response states.
// Free and mark-used: word read, check/write, response.
// Clear all: accept, then response; row valid bits are cleared at once.
// Synchronous reset frees every block and sets block_count to 4096.
// One transaction at a time; req_stall stays high until the response is taken.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator
   import bba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [BLOCK_W-1:0]   req_target_block,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [BLOCK_W-1:0]   rsp_granted_block,
   output logic [COUNT_W-1:0]   rsp_used_total,
   input  logic                 csr_wr_en,
   input  logic [COUNT_W-1:0]   csr_wr_data
);

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [BLOCK_W-1:0]      target_ff, target_in;
   logic [WORD_IDX_W-1:0]   word_ff, word_in;
   logic [WORD_IDX_W-1:0]   chk_ff, chk_in;
   logic [WORD_COUNT-1:0]   valid_ff, valid_in;
   logic [COUNT_W-1:0]      used_ff, used_in;
   logic [COUNT_W-1:0]      limit_ff, limit_in;
   status_type              status_ff, status_in;
   logic [BLOCK_W-1:0]      granted_ff, granted_in;

   logic                    req_accept;
   logic [COUNT_W-1:0]      limit_eff;
   logic [WORD_IDX_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0]    rd_data;
   logic                    wr_en;
   logic [WORD_IDX_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0]    wr_data;

   logic [WORD_IDX_W-1:0]   eff_idx;
   logic [WORD_BITS-1:0]    word_eff;
   logic                    free_found;
   logic [BIT_IDX_W-1:0]    free_idx;
   logic [COUNT_W-1:0]      scan_base;
   logic [COUNT_W-1:0]      scan_cand;
   logic                    scan_past;
   logic                    scan_grant;
   logic                    scan_done;
   logic [WORD_IDX_W-1:0]   tgt_word;
   logic [BIT_IDX_W-1:0]    tgt_bit;
   logic                    tgt_range;
   logic                    tgt_cur;
   logic                    mark_use;

   assign req_accept = req_valid && !req_stall;
   assign limit_eff  = (limit_ff < COUNT_W'(MAX_BLOCKS)) ? limit_ff : COUNT_W'(MAX_BLOCKS);

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // word under test; rows never written since clear read as free
   assign tgt_word = target_ff[BIT_IDX_W +: WORD_IDX_W];
   assign tgt_bit  = target_ff[BIT_IDX_W-1:0];
   assign eff_idx  = (state_ff == S_MARK) ? tgt_word : chk_ff;
   assign word_eff = valid_ff[eff_idx] ? rd_data : '0;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word_eff[i]) begin
            free_found = 1'b1;
            free_idx   = BIT_IDX_W'(i);
         end
      end
   end

   assign scan_base  = COUNT_W'({chk_ff, {BIT_IDX_W{1'b0}}});
   assign scan_cand  = COUNT_W'({chk_ff, free_idx});
   assign scan_past  = scan_base >= limit_eff;
   assign scan_grant = !scan_past && free_found && (scan_cand < limit_eff);
   assign scan_done  = scan_past || free_found || (chk_ff == WORD_IDX_W'(WORD_COUNT - 1));

   assign tgt_range = COUNT_W'(target_ff) >= limit_eff;
   assign tgt_cur   = word_eff[tgt_bit];
   assign mark_use  = (cmd_ff == CMD_MARK);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (cmd_type'(req_command))
                  CMD_ALLOC: state_in = S_SCAN;
                  CMD_FREE,
                  CMD_MARK:  state_in = S_MARK;
                  CMD_CLEAR: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_RESP;
            end
         end
         S_MARK: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in     = cmd_ff;
      target_in  = target_ff;
      word_in    = word_ff;
      chk_in     = chk_ff;
      valid_in   = valid_ff;
      used_in    = used_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      limit_in   = csr_wr_en ? csr_wr_data : limit_ff;
      rd_addr    = word_ff;
      wr_en      = 1'b0;
      wr_addr    = eff_idx;
      wr_data    = word_eff;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            rd_addr   = (cmd_type'(req_command) == CMD_ALLOC) ? '0
                        : req_target_block[BIT_IDX_W +: WORD_IDX_W];
            if (req_accept) begin
               cmd_in     = cmd_type'(req_command);
               target_in  = req_target_block;
               word_in    = WORD_IDX_W'(1);
               chk_in     = '0;
               status_in  = ST_OK;
               granted_in = '0;
               if (cmd_type'(req_command) == CMD_CLEAR) begin
                  valid_in = '0;
                  used_in  = '0;
               end
            end
         end
         S_SCAN: begin
            word_in = word_ff + WORD_IDX_W'(1);
            chk_in  = word_ff;
            if (scan_done) begin
               if (scan_grant) begin
                  wr_en             = 1'b1;
                  wr_data           = word_eff | (WORD_BITS'(1) << free_idx);
                  valid_in[chk_ff]  = 1'b1;
                  used_in           = used_ff + COUNT_W'(1);
                  status_in         = ST_OK;
                  granted_in        = BLOCK_W'(scan_cand);
               end else begin
                  status_in = ST_NOSPACE;
               end
            end
         end
         S_MARK: begin
            priority if (tgt_range) begin
               status_in = ST_RANGE;
            end else if (tgt_cur == mark_use) begin
               status_in = ST_SAME;
            end else begin
               wr_en              = 1'b1;
               wr_data            = mark_use ? (word_eff | (WORD_BITS'(1) << tgt_bit))
                                             : (word_eff & ~(WORD_BITS'(1) << tgt_bit));
               valid_in[tgt_word] = 1'b1;
               used_in            = mark_use ? used_ff + COUNT_W'(1) : used_ff - COUNT_W'(1);
               status_in          = ST_OK;
            end
         end
         S_RESP: rsp_valid = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         used_ff  <= '0;
         limit_ff <= COUNT_W'(MAX_BLOCKS);
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         used_ff  <= used_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      target_ff  <= target_in;
      word_ff    <= word_in;
      chk_ff     <= chk_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_block = granted_ff;
   assign rsp_used_total    = used_ff;

   `BBA_ASSERT(a_no_accept_during_rsp, clock, reset, req_accept |-> !rsp_valid)
   `BBA_ASSERT(a_grant_only_alloc, clock, reset,
      (rsp_valid && rsp_granted_block != '0) |-> (cmd_ff == CMD_ALLOC && status_ff == ST_OK))
   `BBA_ASSERT(a_scan_count_stable, clock, reset,
      (state_ff == S_SCAN && state_in == S_SCAN) |=> $stable(used_ff))
   `BBA_ASSERT(a_free_decrements, clock, reset,
      ($rose(rsp_valid) && cmd_ff == CMD_FREE && status_ff == ST_OK)
      |-> (used_ff == $past(used_ff) - COUNT_W'(1)))
   `BBA_ASSERT_ALWAYS(a_used_bound, clock, reset || (used_ff <= COUNT_W'(MAX_BLOCKS)))

endmodule
